// ----- src/lcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared constants, literal tables and types of the line command recognizer.
// ----------------------------------------------------------------------------
package lcr_pkg;

   localparam int LINE_MAX_DEF = 64;
   localparam int ID_MAX_DEF   = 16;
   localparam int TPFX_LEN     = 22;
   localparam int NEWC_LEN     = 8;
   localparam int NLIT         = 16;
   localparam int LIT_W        = 22;

   // literal indexes
   localparam int B_CMND  = 0;
   localparam int B_WILD  = 1;
   localparam int B_TPFX  = 2;
   localparam int B_TID   = 3;
   localparam int B_CLIST = 4;
   localparam int B_CRESP = 5;
   localparam int B_SREQ  = 6;
   localparam int B_HREQ  = 7;
   localparam int B_CCUR  = 8;
   localparam int B_CREQ  = 9;
   localparam int B_CSTAT = 10;
   localparam int B_CCURR = 11;
   localparam int B_DEV   = 12;
   localparam int B_GAS   = 13;
   localparam int B_NEWC  = 14;
   localparam int B_BRACE = 15;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] reply_type;
   typedef logic [3:0] phase_type;

   localparam reply_type RPL_NONE   = 3'd0;
   localparam reply_type RPL_HBEAT  = 3'd1;
   localparam reply_type RPL_STATUS = 3'd2;
   localparam reply_type RPL_CLIST  = 3'd3;
   localparam reply_type RPL_CCUR   = 3'd4;
   localparam reply_type RPL_GAS    = 3'd5;
   localparam reply_type RPL_IDCHG  = 3'd6;
   localparam reply_type RPL_OVFL   = 3'd7;

   localparam phase_type PH_IDLE   = 4'd0;
   localparam phase_type PH_HDR    = 4'd1;
   localparam phase_type PH_BRACE  = 4'd2;
   localparam phase_type PH_SCHEMA = 4'd3;
   localparam phase_type PH_SREQ   = 4'd4;
   localparam phase_type PH_CRESP  = 4'd5;
   localparam phase_type PH_HREQ   = 4'd6;
   localparam phase_type PH_CCUR   = 4'd7;
   localparam phase_type PH_DEV    = 4'd8;

   typedef struct packed {
      logic [6:0] off;
      logic [4:0] len;
      logic       pfx;
   } lit_info_type;

   function automatic string lit_text(input int k);
      case (k)
         B_CMND:  return "xpl-cmnd";
         B_WILD:  return "target=*";
         B_TPFX:  return "target=linecmd-reader.";
         B_CLIST: return "config.list";
         B_CRESP: return "config.response";
         B_SREQ:  return "sensor.request";
         B_HREQ:  return "hbeat.request";
         B_CCUR:  return "config.current";
         B_CREQ:  return "command=request";
         B_CSTAT: return "command=status";
         B_CCURR: return "command=current";
         B_DEV:   return "device=";
         B_GAS:   return "gas";
         B_NEWC:  return "newconf=";
         B_BRACE: return "}";
         default: return "";
      endcase
   endfunction

   function automatic lit_info_type lit_info(input int k);
      lit_info_type r;
      string        s;
      s     = lit_text(k);
      r.off = (k == B_GAS) ? 7'd7 : 7'd0;
      r.len = 5'(s.len());
      r.pfx = (k == B_TPFX) || (k == B_TID) || (k == B_DEV) || (k == B_GAS) ||
              (k == B_NEWC) || (k == B_BRACE);
      return r;
   endfunction

   // character of literal k at position i of the literal
   function automatic byte_type lit_char(input int k, input logic [4:0] i);
      byte_type c;
      string    s;
      s = lit_text(k);
      c = 8'd0;
      for (int j = 0; j < LIT_W; j++) begin
         if (j < s.len() && 5'(j) == i) begin
            c = s[j];
         end
      end
      return c;
   endfunction

   function automatic byte_type default_id_char(input int i);
      string s;
      s = "default";
      return (i < s.len()) ? byte_type'(s[i]) : 8'd0;
   endfunction

endpackage
`default_nettype wire

// ----- src/lcr_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_stream_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface lcr_stream_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/line_command_recognizer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_command_recognizer_unit
// Byte-stream recognizer for xPL-style command messages.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one received byte per transfer; a newline (10) ends a line.
//  - rsp channel: one result per newline and per overlong line, carrying
//    reply_kind and recognizer_state. Other bytes give no result.
//  - A byte is taken each cycle while req_ready is high. It compares against all
//    literal tables in parallel; the id compare reads the stored instance id
//    ahead of time through the id memory's registered read port, which holds the
//    character at the next line position.
//  - A newline's result is registered: it is in the rsp register in the cycle
//    after the newline transfer.
//  - Reset: after reset the id memory is loaded with "default" in a sweep over
//    all ID_MAX entries, during which req_ready stays low.
//  - Stall: the rsp register holds its result while rsp_ready is low; a new
//    byte is still taken unless it would produce a result into a full
//    register (newline or overflow).
//  - A newconf line copies the pending id into the id memory at one
//    character per cycle; bytes are refused during that copy.
// ----------------------------------------------------------------------------
module line_command_recognizer_unit
   import lcr_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEF,
   parameter int ID_MAX   = ID_MAX_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   lcr_stream_if.sink   req,
   lcr_stream_if.source rsp
);
   localparam int AW = $clog2(ID_MAX);
   localparam int LW = 7;
   localparam int IW = $clog2(ID_MAX + 1);

   byte_type  req_rx_byte;
   assign req_rx_byte = req.data;

   logic [LW-1:0]  line_length_ff, line_length_in;
   logic [NLIT-1:0] flags_ff, flags_in;
   phase_type      phase_ff, phase_in;
   logic [IW-1:0]  own_len_ff, own_len_in;
   logic [IW-1:0]  pend_len_ff, pend_len_in;
   byte_type       pend_ff [ID_MAX];
   logic           rsp_valid_ff, rsp_valid_in;
   reply_type      rsp_reply_ff, rsp_reply_in;
   phase_type      rsp_phase_ff, rsp_phase_in;
   logic           copy_ff, copy_in;
   logic [IW-1:0]  copy_idx_ff, copy_idx_in;

   logic      mem_busy;
   logic      rd_en;
   logic [AW-1:0] rd_addr;
   byte_type  id_char;
   logic      wr_en;

   wire take     = req.valid && req.ready;
   wire is_nl    = (req_rx_byte == 8'd10);
   wire overflow = !is_nl && (line_length_ff >= LW'(LINE_MAX));
   wire makes_rsp = is_nl || overflow;

   assign req.ready = !mem_busy && !copy_ff &&
                      (!rsp_valid_ff || rsp.ready || !makes_rsp);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = {rsp_reply_ff, rsp_phase_ff};

   // id memory: read the character for the next line position ahead of time
   wire [LW:0] next_pos = take ? ((is_nl || overflow) ? '0 : {1'b0, line_length_ff} + 1'b1)
                                : {1'b0, line_length_ff};
   wire [LW:0] id_pos   = next_pos - (LW+1)'(TPFX_LEN);
   assign rd_en   = 1'b1;
   assign rd_addr = id_pos[AW-1:0];
   assign wr_en   = copy_ff && (copy_idx_ff < own_len_ff);

   lcr_id_store #(.ID_MAX(ID_MAX)) u_id_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (id_char),
      .wr_en   (wr_en),
      .wr_addr (copy_idx_ff[AW-1:0]),
      .wr_data (pend_ff[copy_idx_ff[AW-1:0]]),
      .busy    (mem_busy)
   );

   // end-of-line hit test for one literal
   function automatic logic hit(input logic [NLIT-1:0] f, input int k,
                                input logic [LW-1:0] n, input logic [IW-1:0] olen);
      lit_info_type li;
      logic [LW:0]  e;
      li = lit_info(k);
      e  = (LW+1)'(li.off) + (LW+1)'(li.len);
      if (!f[k]) return 1'b0;
      if (k == B_TID) return {1'b0, n} == (LW+1)'(TPFX_LEN) + (LW+1)'(olen);
      return li.pfx ? ({1'b0, n} >= e) : ({1'b0, n} == e);
   endfunction

   // per-character flag update
   always_comb begin
      logic [LW:0] rel;
      logic [LW:0] ip;
      flags_in = flags_ff;
      for (int k = 0; k < NLIT; k++) begin
         if (k != B_TID) begin
            rel = {1'b0, line_length_ff} - (LW+1)'(lit_info(k).off);
            if ({1'b0, line_length_ff} >= (LW+1)'(lit_info(k).off) &&
                rel < (LW+1)'(lit_info(k).len) &&
                lit_char(k, rel[4:0]) != req_rx_byte) begin
               flags_in[k] = 1'b0;
            end
         end
      end
      ip = {1'b0, line_length_ff} - (LW+1)'(TPFX_LEN);
      if (line_length_ff >= LW'(TPFX_LEN)) begin
         if (ip >= (LW+1)'(own_len_ff) || ip >= (LW+1)'(ID_MAX) || id_char != req_rx_byte) begin
            flags_in[B_TID] = 1'b0;
         end
      end
   end

   // line end and phase logic
   always_comb begin
      logic [LW:0] pi;
      phase_in     = phase_ff;
      line_length_in = line_length_ff;
      pend_len_in  = pend_len_ff;
      own_len_in   = own_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_reply_in = rsp_reply_ff;
      rsp_phase_in = rsp_phase_ff;
      copy_in      = copy_ff;
      copy_idx_in  = copy_idx_ff;
      pi = {1'b0, line_length_ff} - (LW+1)'(NEWC_LEN);
      if (copy_ff) begin
         copy_idx_in = copy_idx_ff + 1'b1;
         if (copy_idx_ff + 1'b1 >= own_len_ff || copy_idx_ff + 1'b1 >= IW'(ID_MAX)) begin
            copy_in = 1'b0;
         end
      end
      if (take) begin
         if (overflow) begin
            phase_in = PH_IDLE;
            line_length_in = '0;
            pend_len_in = '0;
            rsp_valid_in = 1'b1;
            rsp_reply_in = RPL_OVFL;
            rsp_phase_in = PH_IDLE;
         end else if (!is_nl) begin
            line_length_in = line_length_ff + 1'b1;
            if (line_length_ff >= LW'(NEWC_LEN) && pi < (LW+1)'(ID_MAX)) begin
               pend_len_in = IW'(pi + 1'b1);
            end
         end else begin
            rsp_reply_in = RPL_NONE;
            case (phase_ff)
               PH_HDR: begin
                  if (hit(flags_ff, B_WILD, line_length_ff, own_len_ff)) phase_in = PH_BRACE;
                  else if (hit(flags_ff, B_TPFX, line_length_ff, own_len_ff))
                     phase_in = hit(flags_ff, B_TID, line_length_ff, own_len_ff) ?
                                PH_BRACE : PH_IDLE;
               end
               PH_BRACE: begin
                  if (hit(flags_ff, B_BRACE, line_length_ff, own_len_ff)) phase_in = PH_SCHEMA;
               end
               PH_SCHEMA: begin
                  if (hit(flags_ff, B_CLIST, line_length_ff, own_len_ff)) begin
                     phase_in = PH_IDLE; rsp_reply_in = RPL_CLIST;
                  end else if (hit(flags_ff, B_CRESP, line_length_ff, own_len_ff))
                     phase_in = PH_CRESP;
                  else if (hit(flags_ff, B_SREQ, line_length_ff, own_len_ff))
                     phase_in = PH_SREQ;
                  else if (hit(flags_ff, B_HREQ, line_length_ff, own_len_ff))
                     phase_in = PH_HREQ;
                  else if (hit(flags_ff, B_CCUR, line_length_ff, own_len_ff))
                     phase_in = PH_CCUR;
                  else phase_in = PH_IDLE;
               end
               PH_SREQ: begin
                  if (hit(flags_ff, B_CSTAT, line_length_ff, own_len_ff)) begin
                     phase_in = PH_IDLE; rsp_reply_in = RPL_STATUS;
                  end else if (hit(flags_ff, B_CCURR, line_length_ff, own_len_ff))
                     phase_in = PH_DEV;
               end
               PH_CRESP: begin
                  if (hit(flags_ff, B_NEWC, line_length_ff, own_len_ff)) begin
                     phase_in = PH_IDLE; rsp_reply_in = RPL_IDCHG;
                     own_len_in = pend_len_ff;
                     copy_in = (pend_len_ff != '0);
                     copy_idx_in = '0;
                  end
               end
               PH_HREQ: begin
                  if (hit(flags_ff, B_CREQ, line_length_ff, own_len_ff)) begin
                     phase_in = PH_IDLE; rsp_reply_in = RPL_HBEAT;
                  end
               end
               PH_CCUR: begin
                  if (hit(flags_ff, B_CREQ, line_length_ff, own_len_ff)) begin
                     phase_in = PH_IDLE; rsp_reply_in = RPL_CCUR;
                  end
               end
               PH_DEV: begin
                  if (hit(flags_ff, B_DEV, line_length_ff, own_len_ff) &&
                      hit(flags_ff, B_GAS, line_length_ff, own_len_ff))
                     rsp_reply_in = RPL_GAS;
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = hit(flags_ff, B_CMND, line_length_ff, own_len_ff) ?
                             PH_HDR : PH_IDLE;
               end
            endcase
            line_length_in = '0;
            pend_len_in = '0;
            rsp_valid_in = 1'b1;
            rsp_phase_in = phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         line_length_ff <= '0;
         flags_ff       <= '1;
         own_len_ff     <= IW'(7);
         pend_len_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         copy_ff        <= 1'b0;
         copy_idx_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         line_length_ff <= line_length_in;
         flags_ff       <= (take && !makes_rsp) ? flags_in : (take ? '1 : flags_ff);
         own_len_ff     <= own_len_in;
         pend_len_ff    <= pend_len_in;
         rsp_valid_ff   <= rsp_valid_in;
         copy_ff        <= copy_in;
         copy_idx_ff    <= copy_idx_in;
      end
   end

   // hold the result payload; capture pending id characters
   always_ff @(posedge clock) begin
      rsp_reply_ff <= rsp_reply_in;
      rsp_phase_ff <= rsp_phase_in;
      if (take && !is_nl && !overflow && line_length_ff >= LW'(NEWC_LEN) &&
          ({1'b0, line_length_ff} - (LW+1)'(NEWC_LEN)) < (LW+1)'(ID_MAX)) begin
         pend_ff[AW'({1'b0, line_length_ff} - (LW+1)'(NEWC_LEN))] <= req_rx_byte;
      end
   end

   // a held result stays put while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp.data))
      else $error("result changed while stalled");
   // no byte taken during the id copy
   a_copy_block: assert property (@(posedge clock) disable iff (reset)
      copy_ff |-> !req.ready)
      else $error("byte accepted during id copy");
   // line length never exceeds its limit
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      line_length_ff <= LW'(LINE_MAX))
      else $error("line length overran");
endmodule
`default_nettype wire

// ----- src/lcr_id_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_id_store
// Instance id memory with a registered synchronous read and a copy port.
// ----------------------------------------------------------------------------
module lcr_id_store
   import lcr_pkg::*;
#(
   parameter int ID_MAX = ID_MAX_DEF,
   localparam int AW    = $clog2(ID_MAX)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      byte_type      rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire byte_type      wr_data,
   output      logic          busy
);
   byte_type        mem [ID_MAX];
   logic [AW:0]     init_cnt_ff;
   logic [AW:0]     init_cnt_in;

   assign busy        = (init_cnt_ff != (AW+1)'(ID_MAX));
   assign init_cnt_in = busy ? init_cnt_ff + 1'b1 : init_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
      end else begin
         init_cnt_ff <= init_cnt_in;
      end
   end

   // load the default id during the sweep after reset
   always_ff @(posedge clock) begin
      if (busy) begin
         mem[init_cnt_ff[AW-1:0]] <= default_id_char(int'(init_cnt_ff));
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire
